// ----- src/rttc_pkg.sv -----
// Shared types and constants for the repeating task timer channels.
package rttc_pkg;

   localparam int CHANNELS_DEFAULT     = 2;
   localparam int COUNT_BITS_DEFAULT   = 32;
   localparam int FOREVER_CODE_DEFAULT = 255;

   localparam int FUNC_BITS   = 2;
   localparam int PERIOD_BITS = 8;
   localparam int REPEAT_BITS = 8;
   localparam int RATE_BITS   = 18;

   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(24000);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   // Per-channel commands from the execute stage.
   typedef struct packed {
      logic tick;
      logic load;
      logic cancel;
   } chan_ctl_type;

   // Per-channel status back to the execute stage.
   typedef struct packed {
      logic active;
      logic fire;
      logic done;
   } chan_stat_type;

endpackage

// ----- src/repeating_task_timer_channels.sv -----
// Top level: command register, channel bank, start arbitration and result register.
// Every command (tick, start, cancel, read) is accepted as issued, so busy
// never rises and a command may be issued on every cycle. A command is captured in
// an input register, executed in the following cycle by the channel bank and the
// 18 x 8 bit reload multiplier, and its result is registered and shown with rsp_valid
// high for one cycle. The receiver cannot stall the result stream, so each result
// must be taken in the cycle it is shown. ticks_per_ms should be written only while
// no command is in flight.
module repeating_task_timer_channels #(
   parameter int CHANNELS     = rttc_pkg::CHANNELS_DEFAULT,
   parameter int COUNT_BITS   = rttc_pkg::COUNT_BITS_DEFAULT,
   parameter int FOREVER_CODE = rttc_pkg::FOREVER_CODE_DEFAULT,
   localparam int IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [rttc_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [IDX_BITS-1:0]              req_channel,
   input  logic [rttc_pkg::PERIOD_BITS-1:0] req_period_ms,
   input  logic [rttc_pkg::REPEAT_BITS-1:0] req_repeats,
   output logic                             rsp_valid,
   output logic                             rsp_start_ok,
   output logic [IDX_BITS-1:0]              rsp_granted_channel,
   output logic [CHANNELS-1:0]              rsp_fire_mask,
   output logic [CHANNELS-1:0]              rsp_done_mask,
   output logic [COUNT_BITS-1:0]            rsp_count_value,
   input  logic                             csr_we,
   input  logic [rttc_pkg::RATE_BITS-1:0]   csr_wdata
);

   localparam int PROD_BITS = rttc_pkg::RATE_BITS + rttc_pkg::PERIOD_BITS;
   localparam int WIDE_BITS = (COUNT_BITS > PROD_BITS) ? COUNT_BITS : PROD_BITS;

   logic [rttc_pkg::RATE_BITS-1:0]   rate_ff;

   logic                             req_valid_ff;
   rttc_pkg::func_type               func_ff;
   logic [IDX_BITS-1:0]              channel_ff;
   logic [rttc_pkg::PERIOD_BITS-1:0] period_ff;
   logic [rttc_pkg::REPEAT_BITS-1:0] repeats_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_start_ok_ff, rsp_start_ok_in;
   logic [IDX_BITS-1:0]              rsp_granted_ff, rsp_granted_in;
   logic [CHANNELS-1:0]              rsp_fire_ff, rsp_fire_in;
   logic [CHANNELS-1:0]              rsp_done_ff, rsp_done_in;
   logic [COUNT_BITS-1:0]            rsp_count_ff, rsp_count_in;

   rttc_pkg::chan_ctl_type           ctl   [CHANNELS];
   rttc_pkg::chan_stat_type          stat  [CHANNELS];
   logic [COUNT_BITS-1:0]            counts[CHANNELS];
   logic [CHANNELS-1:0]              active_mask;
   logic [CHANNELS-1:0]              fire_mask;
   logic [CHANNELS-1:0]              done_mask;

   logic                             grant_found;
   logic [IDX_BITS-1:0]              grant_idx;
   logic [WIDE_BITS-1:0]             product;
   logic [COUNT_BITS-1:0]            reload_value;
   logic [COUNT_BITS-1:0]            read_count;

   assign busy = 1'b0;

   // Rate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= rttc_pkg::RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   // Command register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= rttc_pkg::func_type'(req_func);
      channel_ff <= req_channel;
      period_ff  <= req_period_ms;
      repeats_ff <= req_repeats;
   end

   // A zero product wraps to all ones, as the reload is the product minus one.
   assign product      = WIDE_BITS'(rate_ff) * WIDE_BITS'(period_ff);
   assign reload_value = COUNT_BITS'(product - WIDE_BITS'(1));

   // Lowest free channel wins a start.
   always_comb begin
      grant_found = 1'b0;
      grant_idx   = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (!active_mask[c]) begin
            grant_found = 1'b1;
            grant_idx   = IDX_BITS'(c);
         end
      end
   end

   always_comb begin
      read_count = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (channel_ff == IDX_BITS'(c)) begin
            read_count = counts[c];
         end
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : gen_chan
      assign ctl[g].tick   = req_valid_ff && (func_ff == rttc_pkg::FUNC_TICK);
      assign ctl[g].load   = req_valid_ff && (func_ff == rttc_pkg::FUNC_START) &&
                             grant_found && (grant_idx == IDX_BITS'(g));
      assign ctl[g].cancel = req_valid_ff && (func_ff == rttc_pkg::FUNC_CANCEL) &&
                             (channel_ff == IDX_BITS'(g));

      rttc_channel #(
         .COUNT_BITS   (COUNT_BITS),
         .FOREVER_CODE (FOREVER_CODE)
      ) u_channel (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl[g]),
         .load_value   (reload_value),
         .load_repeats (repeats_ff),
         .stat         (stat[g]),
         .count        (counts[g])
      );

      assign active_mask[g] = stat[g].active;
      assign fire_mask[g]   = stat[g].fire;
      assign done_mask[g]   = stat[g].done;
   end

   always_comb begin
      rsp_start_ok_in = 1'b0;
      rsp_granted_in  = '0;
      rsp_fire_in     = '0;
      rsp_done_in     = '0;
      rsp_count_in    = '0;
      case (func_ff)
         rttc_pkg::FUNC_TICK: begin
            rsp_fire_in = fire_mask;
            rsp_done_in = done_mask;
         end
         rttc_pkg::FUNC_START: begin
            rsp_start_ok_in = grant_found;
            rsp_granted_in  = grant_found ? grant_idx : '0;
         end
         rttc_pkg::FUNC_READ: begin
            rsp_count_in = read_count;
         end
         default: begin
            rsp_start_ok_in = 1'b0;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_start_ok_ff <= rsp_start_ok_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_fire_ff     <= rsp_fire_in;
      rsp_done_ff     <= rsp_done_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_start_ok        = rsp_start_ok_ff;
   assign rsp_granted_channel = rsp_granted_ff;
   assign rsp_fire_mask       = rsp_fire_ff;
   assign rsp_done_mask       = rsp_done_ff;
   assign rsp_count_value     = rsp_count_ff;

   // Every captured command produces exactly one result beat in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid_ff)
      else $error("command did not produce a result beat");

   // A channel can only be freed on a tick in which it fired.
   a_done_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_done_ff & ~rsp_fire_ff) == '0)
      else $error("channel freed without firing");

   // A successful start leaves its granted channel running when reported.
   a_grant_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_start_ok_ff) |-> active_mask[rsp_granted_ff])
      else $error("granted channel is not active");

   // Reset frees every channel.
   a_reset_free: assert property (@(posedge clock)
      $past(reset) |-> (active_mask == '0))
      else $error("channel active after reset");

endmodule

// ----- src/rttc_channel.sv -----
// One down-counting timer channel with reload value and repeat count.
module rttc_channel #(
   parameter int COUNT_BITS   = rttc_pkg::COUNT_BITS_DEFAULT,
   parameter int FOREVER_CODE = rttc_pkg::FOREVER_CODE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rttc_pkg::chan_ctl_type           ctl,
   input  logic [COUNT_BITS-1:0]            load_value,
   input  logic [rttc_pkg::REPEAT_BITS-1:0] load_repeats,
   output rttc_pkg::chan_stat_type          stat,
   output logic [COUNT_BITS-1:0]            count
);

   localparam logic [rttc_pkg::REPEAT_BITS-1:0] FOREVER =
      rttc_pkg::REPEAT_BITS'(FOREVER_CODE);

   logic                             active_ff, active_in;
   logic [COUNT_BITS-1:0]            reload_ff, reload_in;
   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic [rttc_pkg::REPEAT_BITS-1:0] repeats_ff, repeats_in;
   logic [rttc_pkg::REPEAT_BITS-1:0] repeats_dec;
   logic                             fire, done;

   always_comb begin
      active_in   = active_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      repeats_in  = repeats_ff;
      fire        = 1'b0;
      done        = 1'b0;
      repeats_dec = repeats_ff;
      if (ctl.tick && active_ff) begin
         if (count_ff == '0) begin
            count_in = reload_ff;
            fire     = 1'b1;
            // The forever code and a zero count are left alone.
            if (repeats_ff != FOREVER && repeats_ff != '0) begin
               repeats_dec = repeats_ff - rttc_pkg::REPEAT_BITS'(1);
            end
            repeats_in = repeats_dec;
            if (repeats_dec == '0) begin
               active_in = 1'b0;
               done      = 1'b1;
            end
         end else begin
            count_in = count_ff - COUNT_BITS'(1);
         end
      end else if (ctl.load) begin
         active_in  = 1'b1;
         reload_in  = load_value;
         count_in   = load_value;
         repeats_in = load_repeats;
      end else if (ctl.cancel) begin
         active_in  = 1'b0;
         repeats_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         reload_ff  <= '0;
         count_ff   <= '0;
         repeats_ff <= '0;
      end else begin
         active_ff  <= active_in;
         reload_ff  <= reload_in;
         count_ff   <= count_in;
         repeats_ff <= repeats_in;
      end
   end

   assign stat.active = active_ff;
   assign stat.fire   = fire;
   assign stat.done   = done;
   assign count       = count_ff;

endmodule

// ----- tb/timer_channel_checker.sv -----
`timescale 1ns / 1ps
// Checker for the timer channels: tracks accepted commands, predicts each response and compares.
module timer_channel_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [rttc_pkg::FUNC_BITS-1:0]   req_func,
   input  logic                             req_channel,
   input  logic [rttc_pkg::PERIOD_BITS-1:0] req_period_ms,
   input  logic [rttc_pkg::REPEAT_BITS-1:0] req_repeats,
   input  logic                             rsp_valid,
   input  logic                             rsp_start_ok,
   input  logic                             rsp_granted_channel,
   input  logic [1:0]                       rsp_fire_mask,
   input  logic [1:0]                       rsp_done_mask,
   input  logic [31:0]                      rsp_count_value,
   input  logic                             csr_we,
   input  logic [rttc_pkg::RATE_BITS-1:0]   csr_wdata,
   output int                               mismatches,
   output int                               outstanding
);

   localparam int NCHAN = rttc_pkg::CHANNELS_DEFAULT;
   localparam logic [rttc_pkg::REPEAT_BITS-1:0] FOREVER =
      rttc_pkg::REPEAT_BITS'(rttc_pkg::FOREVER_CODE_DEFAULT);

   typedef struct packed {
      logic        start_ok;
      logic        granted;
      logic [1:0]  fire;
      logic [1:0]  done;
      logic [31:0] count;
   } timer_answer_type;

   logic [rttc_pkg::RATE_BITS-1:0]   ticks_per_ms;
   logic                             chan_busy    [NCHAN];
   logic [31:0]                      chan_reload  [NCHAN];
   logic [31:0]                      chan_count   [NCHAN];
   logic [rttc_pkg::REPEAT_BITS-1:0] chan_repeats [NCHAN];
   timer_answer_type                 awaited_answers [$];

   function automatic timer_answer_type run_timer_command(
      rttc_pkg::func_type f, logic ch,
      logic [rttc_pkg::PERIOD_BITS-1:0] period,
      logic [rttc_pkg::REPEAT_BITS-1:0] reps);
      timer_answer_type a;
      logic [31:0]      rv;
      logic             found;
      int               c;
      a = '0;
      found = 1'b0;
      // A zero period or rate wraps the reload value to all ones.
      rv = 32'(ticks_per_ms) * 32'(period) - 32'd1;
      case (f)
         rttc_pkg::FUNC_TICK: begin
            for (c = 0; c < NCHAN; c++) begin
               if (chan_busy[c]) begin
                  if (chan_count[c] == 32'd0) begin
                     chan_count[c] = chan_reload[c];
                     a.fire[c] = 1'b1;
                     if (chan_repeats[c] != FOREVER && chan_repeats[c] != '0)
                        chan_repeats[c] = chan_repeats[c] - rttc_pkg::REPEAT_BITS'(1);
                     if (chan_repeats[c] == '0) begin
                        chan_busy[c] = 1'b0;
                        a.done[c] = 1'b1;
                     end
                  end else begin
                     chan_count[c] = chan_count[c] - 32'd1;
                  end
               end
            end
         end
         rttc_pkg::FUNC_START: begin
            for (c = 0; c < NCHAN; c++) begin
               if (!found && !chan_busy[c]) begin
                  found = 1'b1;
                  chan_busy[c] = 1'b1;
                  chan_repeats[c] = reps;
                  chan_reload[c] = rv;
                  chan_count[c] = rv;
                  a.start_ok = 1'b1;
                  a.granted = 1'(c);
               end
            end
         end
         rttc_pkg::FUNC_CANCEL: begin
            chan_busy[ch] = 1'b0;
            chan_repeats[ch] = '0;
         end
         default: begin
            a.count = chan_count[ch];
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      timer_answer_type want;
      timer_answer_type got;
      int c;
      if (reset) begin
         ticks_per_ms = rttc_pkg::RATE_RESET;
         for (c = 0; c < NCHAN; c++) begin
            chan_busy[c] = 1'b0;
            chan_reload[c] = '0;
            chan_count[c] = '0;
            chan_repeats[c] = '0;
         end
         awaited_answers.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_start_ok, rsp_granted_channel, rsp_fire_mask, rsp_done_mask,
                    rsp_count_value};
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected beat: ok=%0b ch=%0b fire=%b done=%b count=%h",
                           $realtime, got.start_ok, got.granted, got.fire, got.done,
                           got.count);
            end else begin
               want = awaited_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch (expected/actual): ok %0b/%0b ch %0b/%0b",
                            $realtime, want.start_ok, got.start_ok, want.granted,
                            got.granted);
                     $display(" fire %b/%b done %b/%b count %h/%h", want.fire, got.fire,
                              want.done, got.done, want.count, got.count);
                  end
               end
            end
         end
         if (csr_we)
            ticks_per_ms = csr_wdata;
         if (start && !busy)
            awaited_answers.push_back(run_timer_command(rttc_pkg::func_type'(req_func),
                                                        req_channel, req_period_ms,
                                                        req_repeats));
      end
      outstanding = awaited_answers.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the timer channel testbench: clock, reset, command stimulus and the verdict.
module tb_top;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 190;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [rttc_pkg::FUNC_BITS-1:0]   req_func;
   logic                             req_channel;
   logic [rttc_pkg::PERIOD_BITS-1:0] req_period_ms;
   logic [rttc_pkg::REPEAT_BITS-1:0] req_repeats;
   logic                             rsp_valid;
   logic                             rsp_start_ok;
   logic                             rsp_granted_channel;
   logic [1:0]                       rsp_fire_mask;
   logic [1:0]                       rsp_done_mask;
   logic [31:0]                      rsp_count_value;
   logic                             csr_we;
   logic [rttc_pkg::RATE_BITS-1:0]   csr_wdata;
   int                               mismatches;
   int                               outstanding;
   int                               idle_cycles;

   logic [rttc_pkg::RATE_BITS-1:0] phase_rates [PHASES] =
      '{18'd1, 18'd2, 18'd0, 18'd262143, 18'd3, 18'd200000, 18'd1, 18'd7};

   repeating_task_timer_channels DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_channel         (req_channel),
      .req_period_ms       (req_period_ms),
      .req_repeats         (req_repeats),
      .rsp_valid           (rsp_valid),
      .rsp_start_ok        (rsp_start_ok),
      .rsp_granted_channel (rsp_granted_channel),
      .rsp_fire_mask       (rsp_fire_mask),
      .rsp_done_mask       (rsp_done_mask),
      .rsp_count_value     (rsp_count_value),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   timer_channel_checker u_timer_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_channel         (req_channel),
      .req_period_ms       (req_period_ms),
      .req_repeats         (req_repeats),
      .rsp_valid           (rsp_valid),
      .rsp_start_ok        (rsp_start_ok),
      .rsp_granted_channel (rsp_granted_channel),
      .rsp_fire_mask       (rsp_fire_mask),
      .rsp_done_mask       (rsp_done_mask),
      .rsp_count_value     (rsp_count_value),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .outstanding         (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Each call ends at a falling edge, so back-to-back beats keep start high throughout.
   task automatic issue_command(input rttc_pkg::func_type f, input logic ch,
                                input logic [rttc_pkg::PERIOD_BITS-1:0] period,
                                input logic [rttc_pkg::REPEAT_BITS-1:0] reps);
      req_func = f;
      req_channel = ch;
      req_period_ms = period;
      req_repeats = reps;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_timer();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_rate(input logic [rttc_pkg::RATE_BITS-1:0] value);
      drain_timer();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic issue_random_command();
      int                               pick;
      rttc_pkg::func_type               f;
      logic [rttc_pkg::PERIOD_BITS-1:0] period;
      logic [rttc_pkg::REPEAT_BITS-1:0] reps;
      pick = $urandom_range(0, 99);
      if (pick < 55) f = rttc_pkg::FUNC_TICK;
      else if (pick < 72) f = rttc_pkg::FUNC_START;
      else if (pick < 82) f = rttc_pkg::FUNC_CANCEL;
      else f = rttc_pkg::FUNC_READ;
      // Short periods keep the channels firing; the rest covers the full field.
      pick = $urandom_range(0, 9);
      if (pick < 6) period = rttc_pkg::PERIOD_BITS'($urandom_range(1, 4));
      else if (pick == 6) period = '0;
      else period = rttc_pkg::PERIOD_BITS'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 5) reps = rttc_pkg::REPEAT_BITS'($urandom_range(0, 3));
      else if (pick < 7) reps = rttc_pkg::REPEAT_BITS'(rttc_pkg::FOREVER_CODE_DEFAULT);
      else reps = rttc_pkg::REPEAT_BITS'($urandom_range(0, 255));
      issue_command(f, 1'($urandom_range(0, 1)), period, reps);
   endtask

   task automatic random_gap();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 65) len = 0;
      else if (pick < 92) len = $urandom_range(1, 3);
      else if (pick < 98) len = $urandom_range(4, 12);
      else len = $urandom_range(20, 60);
      if (len > 0) begin
         start = 1'b0;
         repeat (len) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = rttc_pkg::FUNC_TICK;
      req_channel = 1'b0;
      req_period_ms = '0;
      req_repeats = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // At the reset rate: zero period, full channels, reads and cancels of busy and free channels.
      issue_command(rttc_pkg::FUNC_READ, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_READ, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_START, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_START, 1'b1, 8'd255, 8'd255);
      issue_command(rttc_pkg::FUNC_START, 1'b0, 8'd1, 8'd1);
      issue_command(rttc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_READ, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_READ, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_CANCEL, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_CANCEL, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_READ, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_CANCEL, 1'b0, 8'd0, 8'd0);

      // At one tick per period unit: zero repeat count, a short finite run and a forever task.
      write_rate(18'd1);
      issue_command(rttc_pkg::FUNC_START, 1'b0, 8'd1, 8'd0);
      issue_command(rttc_pkg::FUNC_START, 1'b1, 8'd2, 8'd2);
      repeat (5) issue_command(rttc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_READ, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_START, 1'b0, 8'd3, 8'd255);
      repeat (4) issue_command(rttc_pkg::FUNC_TICK, 1'b1, 8'd0, 8'd0);
      issue_command(rttc_pkg::FUNC_CANCEL, 1'b0, 8'd0, 8'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_rate(phase_rates[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue_random_command();
            // Every third phase runs without any gaps.
            if (ph % 3 != 2) begin
               random_gap();
               if ($urandom_range(0, 99) == 0)
                  drain_timer();
            end
         end
      end

      drain_timer();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
src/rttc_pkg.sv
src/rttc_channel.sv
src/repeating_task_timer_channels.sv
tb/timer_channel_checker.sv
tb/tb_top.sv
